// File: rtl/vn3d_pkg.sv
// vn3d_pkg: shared widths and stage payload types for vector_normalize_3d
// no dependencies
package vn3d_pkg;
	localparam int CompW  = 16;
	localparam int MagW   = 16;
	localparam int SumW   = 32;
	localparam int QW     = 15;   // quotient 0..16384
	localparam int NumW   = 30;   // |c| << 14
	localparam int RootSteps = 16;
	localparam int DivSteps  = 15;

	// per-component payload carried down the pipeline
	typedef struct packed {
		logic            neg;
		logic [CompW-1:0] absv;
	} comp_t;

	typedef struct packed {
		comp_t [2:0] c;
	} vec_t;
endpackage

// File: rtl/vn3d_sqrt.sv
// vn3d_sqrt: pipelined integer square root, one result bit per stage
// depends on vn3d_pkg
module vn3d_sqrt import vn3d_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  logic [SumW-1:0] in_sum,
	input  vec_t            in_vec,
	output logic            out_valid,
	output logic [MagW-1:0] out_root,
	output vec_t            out_vec
);
	// remainder/root restoring sqrt; stage k decides root bit (15-k)
	logic [RootSteps:0]           vld_s;
	logic [RootSteps:0][SumW-1:0] rem_s;
	logic [RootSteps:0][MagW-1:0] root_s;
	vec_t [RootSteps:0]           vec_s;

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = in_sum;
	assign root_s[0] = '0;
	assign vec_s[0]  = in_vec;

	for (genvar k = 0; k < RootSteps; k++) begin : g_stage
		localparam int B = RootSteps - 1 - k;
		logic [SumW+1:0] trial;
		logic            take;
		// trial = (2*root*2^B + 2^(2B)) with root holding the high bits
		assign trial = ({2'b0, 16'b0, root_s[k]} << (B + 1)) + ({{SumW+1{1'b0}}, 1'b1} << (2 * B));
		assign take  = {2'b0, rem_s[k]} >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1]  <= take ? rem_s[k] - trial[SumW-1:0] : rem_s[k];
				root_s[k+1] <= take ? (root_s[k] | (MagW'(1) << B)) : root_s[k];
				vec_s[k+1]  <= vec_s[k];
			end
		end
	end

	assign out_valid = vld_s[RootSteps];
	assign out_root  = root_s[RootSteps];
	assign out_vec   = vec_s[RootSteps];
endmodule

// File: rtl/vn3d_div.sv
// vn3d_div: pipelined restoring divider for three components sharing one divisor
// depends on vn3d_pkg
module vn3d_div import vn3d_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  logic [MagW-1:0]       in_mag,
	input  vec_t                  in_vec,
	output logic                  out_valid,
	output logic [MagW-1:0]       out_mag,
	output logic [2:0]            out_neg,
	output logic [2:0][QW-1:0]    out_quo
);
	// quotient < 2^15 since |c| <= mag; stage k decides bit (14-k)
	logic [DivSteps:0]                 vld_s;
	logic [DivSteps:0][MagW-1:0]       mag_s;
	logic [DivSteps:0][2:0]            neg_s;
	logic [DivSteps:0][2:0][NumW-1:0]  rem_s;
	logic [DivSteps:0][2:0][QW-1:0]    quo_s;

	assign vld_s[0] = in_valid;
	assign mag_s[0] = in_mag;
	for (genvar i = 0; i < 3; i++) begin : g_in
		assign neg_s[0][i] = in_vec.c[i].neg;
		assign rem_s[0][i] = {in_vec.c[i].absv, 14'b0};
		assign quo_s[0][i] = '0;
	end

	for (genvar k = 0; k < DivSteps; k++) begin : g_stage
		localparam int B = DivSteps - 1 - k;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		for (genvar i = 0; i < 3; i++) begin : g_lane
			logic [NumW+QW-1:0] dsh;
			logic               take;
			assign dsh  = {{NumW+QW-MagW{1'b0}}, mag_s[k]} << B;
			assign take = (mag_s[k] != '0) && ({{QW{1'b0}}, rem_s[k][i]} >= dsh);
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[k+1][i] <= take ? rem_s[k][i] - dsh[NumW-1:0] : rem_s[k][i];
					quo_s[k+1][i] <= take ? (quo_s[k][i] | (QW'(1) << B)) : quo_s[k][i];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				mag_s[k+1] <= mag_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	assign out_valid = vld_s[DivSteps];
	assign out_mag   = mag_s[DivSteps];
	assign out_neg   = neg_s[DivSteps];
	assign out_quo   = quo_s[DivSteps];
endmodule

// File: rtl/vector_normalize_3d.sv
// vector_normalize_3d: magnitude and unit vector of a signed 3-D vector
// one stream in, one stream out, fully pipelined
// uses vn3d_pkg, vn3d_sqrt, vn3d_div
//
// s_axis: tdata carries comp_x, comp_y, comp_z (16 bits each, signed)
// m_axis: tdata carries unit_x, unit_y, unit_z (signed Q1.14) and magnitude;
//   tuser carries zero_vector, set for an all-zero input (units then zero)
// pipeline stages: square stage, sum stage, 16 root stages, 15 divider
//   stages, output register that also applies the signs
// throughput: one vector per cycle while the receiver does not stall; the
//   one-bit-per-stage root and the one-bit-per-stage shared-divisor divider set the depth
// the whole pipeline advances when the output register is empty or taken;
//   when the receiver stalls every stage holds, so s_axis_tready drops
// reset clears all valid bits; payload registers are not reset
module vector_normalize_3d import vn3d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // comp_x, comp_y, comp_z
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // unit_x, unit_y, unit_z, magnitude
	output logic        m_axis_tuser    // zero_vector
);
	logic adv;
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// stage 1: abs values and squares
	logic                   vld_s1, vld_s2;
	vec_t                   vec_s1, vec_s2, vec_in;
	logic [2:0][SumW-1:0]   sq_s1;
	logic [SumW-1:0]        sum_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [CompW-1:0] c;
			c = s_axis_tdata[i*CompW +: CompW];
			vec_in.c[i].neg  = c[CompW-1];
			vec_in.c[i].absv = c[CompW-1] ? CompW'(-c) : c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vec_s1 <= vec_in;
			for (int i = 0; i < 3; i++)
				sq_s1[i] <= {16'b0, vec_in.c[i].absv} * {16'b0, vec_in.c[i].absv};
			vec_s2 <= vec_s1;
			sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		end
	end

	logic            sq_valid;
	logic [MagW-1:0] sq_root;
	vec_t            sq_vec;

	vn3d_sqrt u_sqrt (
		.clk, .arst_n, .adv,
		.in_valid(vld_s2), .in_sum(sum_s2), .in_vec(vec_s2),
		.out_valid(sq_valid), .out_root(sq_root), .out_vec(sq_vec)
	);

	logic                dv_valid;
	logic [MagW-1:0]     dv_mag;
	logic [2:0]          dv_neg;
	logic [2:0][QW-1:0]  dv_quo;

	vn3d_div u_div (
		.clk, .arst_n, .adv,
		.in_valid(sq_valid), .in_mag(sq_root), .in_vec(sq_vec),
		.out_valid(dv_valid), .out_mag(dv_mag), .out_neg(dv_neg), .out_quo(dv_quo)
	);

	// output register: apply signs, flag zero magnitude
	logic [2:0][CompW-1:0] unit_q;
	logic [MagW-1:0]       mag_q;
	logic                  zero_q;
	logic                  vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				unit_q[i] <= dv_neg[i] ? CompW'(-{1'b0, dv_quo[i]}) : {1'b0, dv_quo[i]};
			mag_q  <= dv_mag;
			zero_q <= (dv_mag == '0);
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata  = {mag_q, unit_q[2], unit_q[1], unit_q[0]};
	assign m_axis_tuser  = zero_q;

`ifndef SYNTHESIS
	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not track output stage");
	a_zero_units: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[47:0] == 48'b0)
		else $error("zero vector with nonzero units");
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");
`endif
endmodule
